/* rtl/rbm_pkg.sv */
package rbm_pkg;

    localparam int DATA_W           = 32;
    localparam int CORDIC_STEPS_DEF = 24;
    localparam int CFG_IDX_W        = 8;

    // datapath widths
    localparam int ROOT_W = 33;   // floor sqrt of a 65-bit sum
    localparam int RAD_W  = 66;   // radicand, two bits per root digit
    localparam int REM_W  = 36;   // sqrt partial remainder
    localparam int VEC_W  = 36;   // CORDIC vector and angle arithmetic
    localparam int ANG_W  = 33;   // CORDIC angle accumulator
    localparam int QUO_W  = 31;   // quotient bits below the saturation limit
    localparam int R2_W   = 2 * ROOT_W;
    localparam int WRAP_N = 7;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_NOISE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BEARING_NOISE = 8'd1;

    localparam logic signed [VEC_W-1:0] PI_Q     = 36'sd843314856;
    localparam logic signed [VEC_W-1:0] TWO_PI_Q = 36'sd1686629713;
    localparam logic signed [ANG_W-1:0] PI_ANG   = 33'sd843314856;
    localparam logic signed [VEC_W-1:0] SAT_HI   = 36'sd2147483647;
    localparam logic signed [VEC_W-1:0] SAT_LO   = -36'sd2147483648;

    // offsets k * 2pi, k = -3 .. 3, for the floor modulo
    localparam logic signed [VEC_W-1:0] WRAP_OFS [WRAP_N] = '{
        -36'sd5059889139, -36'sd3373259426, -36'sd1686629713, 36'sd0,
        36'sd1686629713, 36'sd3373259426, 36'sd5059889139
    };

    // front pipeline: entry, squares, sum, square root and CORDIC steps
    typedef struct packed {
        logic [DATA_W-1:0]        ax;
        logic [DATA_W-1:0]        ay;
        logic                     dx_pos;
        logic                     dy_pos;
        logic                     dy_neg;
        logic                     degen;
        logic signed [DATA_W-1:0] hd;
        logic signed [DATA_W-1:0] refa;
        logic signed [VEC_W-1:0]  cx;
        logic signed [VEC_W-1:0]  cy;
        logic signed [ANG_W-1:0]  cz;
        logic [RAD_W-1:0]         rad;
        logic [REM_W-1:0]         rem;
        logic [ROOT_W-1:0]        root;
    } front_t;

    // stage between root and division
    typedef struct packed {
        logic [DATA_W-1:0]        ax;
        logic [DATA_W-1:0]        ay;
        logic [ROOT_W-1:0]        r;
        logic [R2_W-1:0]          r2;
        logic signed [VEC_W-1:0]  t;
        logic signed [DATA_W-1:0] refa;
        logic                     dx_pos;
        logic                     dy_pos;
        logic                     dy_neg;
        logic                     degen;
    } back_t;

    // side lane that runs beside the dividers
    typedef struct packed {
        logic signed [VEC_W-1:0]  b;
        logic signed [DATA_W-1:0] refa;
        logic [ROOT_W-1:0]        r;
        logic                     dx_pos;
        logic                     dy_pos;
        logic                     dy_neg;
        logic                     degen;
    } side_t;

    // rounded arctangent of 2^-i in Q3.28
    function automatic logic [DATA_W-1:0] atan_entry(input logic [4:0] i);
        case (i)
            5'd0:    return 32'd210828714;
            5'd1:    return 32'd124459457;
            5'd2:    return 32'd65760959;
            5'd3:    return 32'd33381290;
            5'd4:    return 32'd16755422;
            5'd5:    return 32'd8385879;
            5'd6:    return 32'd4193963;
            5'd7:    return 32'd2097109;
            5'd8:    return 32'd1048571;
            5'd9:    return 32'd524287;
            5'd10:   return 32'd262144;
            5'd11:   return 32'd131072;
            5'd12:   return 32'd65536;
            5'd13:   return 32'd32768;
            5'd14:   return 32'd16384;
            5'd15:   return 32'd8192;
            5'd16:   return 32'd4096;
            5'd17:   return 32'd2048;
            5'd18:   return 32'd1024;
            5'd19:   return 32'd512;
            5'd20:   return 32'd256;
            5'd21:   return 32'd128;
            5'd22:   return 32'd64;
            5'd23:   return 32'd32;
            5'd24:   return 32'd16;
            5'd25:   return 32'd8;
            5'd26:   return 32'd4;
            5'd27:   return 32'd2;
            5'd28:   return 32'd1;
            default: return 32'd0;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [VEC_W-1:0] v);
        if (v > SAT_HI) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < SAT_LO) begin
            return 32'sh8000_0000;
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

/* rtl/range_bearing_measurement_model_core.sv */
// Range/bearing measurement model for a 2-D beacon EKF, fully pipelined.
//
// Input channel (meas_valid / meas_stall): one robot pose, beacon position
// and reference angle per transaction. Output channel (result_valid /
// result_stall): predicted range and bearing plus noise means, the four
// Jacobian partials and the degenerate flag, one transaction per input.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0
// is the range noise mean, index 1 the bearing noise mean; other indexes
// are dropped. cfg_ready is always high; write only while the pipe is empty.
//
// Stages: 3 entry stages, 33 square-root digit stages (one
// CORDIC step rides along in each of the first CORDIC_STEPS of them), one
// r^2 multiply stage, 31 divider bit stages and the output register.
// One transaction per cycle while the receiver does not stall with a
// result waiting; the dividers produce one quotient bit per stage.
// Reset clears all valid bits and both noise means. When the receiver
// stalls with a result waiting, the whole pipe holds and meas_stall rises.
module range_bearing_measurement_model_core #(
    parameter int CORDIC_STEPS = rbm_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 meas_valid,
    output logic                                 meas_stall,
    input  logic signed [rbm_pkg::DATA_W-1:0]    robot_x,
    input  logic signed [rbm_pkg::DATA_W-1:0]    robot_y,
    input  logic signed [rbm_pkg::DATA_W-1:0]    robot_heading,
    input  logic signed [rbm_pkg::DATA_W-1:0]    beacon_x,
    input  logic signed [rbm_pkg::DATA_W-1:0]    beacon_y,
    input  logic signed [rbm_pkg::DATA_W-1:0]    reference_angle,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic signed [rbm_pkg::DATA_W-1:0]    predicted_range,
    output logic signed [rbm_pkg::DATA_W-1:0]    predicted_bearing,
    output logic signed [rbm_pkg::DATA_W-1:0]    range_by_x,
    output logic signed [rbm_pkg::DATA_W-1:0]    range_by_y,
    output logic signed [rbm_pkg::DATA_W-1:0]    bearing_by_x,
    output logic signed [rbm_pkg::DATA_W-1:0]    bearing_by_y,
    output logic                                 degenerate,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rbm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rbm_pkg::DATA_W-1:0]           cfg_data
);
    import rbm_pkg::*;

    localparam int FRONT_N = 3 + ROOT_W;

    // ---------------------------------------------------------------
    // Stage functions
    // ---------------------------------------------------------------

    // one digit of the floor square root, digit index k counts down
    function automatic front_t sqrt_step(input front_t p, input int k);
        front_t             n;
        logic [1:0]         pair;
        logic [REM_W-1:0]   rem_s;
        logic [ROOT_W-1:0]  root_s;
        logic [REM_W-1:0]   trial;
        n      = p;
        pair   = 2'(p.rad >> (2 * k));
        rem_s  = {p.rem[REM_W-3:0], pair};
        root_s = {p.root[ROOT_W-2:0], 1'b0};
        trial  = REM_W'({root_s, 1'b1});
        if (rem_s >= trial)
        begin
            n.rem  = rem_s - trial;
            n.root = root_s | ROOT_W'(1);
        end
        else
        begin
            n.rem  = rem_s;
            n.root = root_s;
        end
        return n;
    endfunction

    // one CORDIC vectoring step, driving y toward zero
    function automatic front_t cordic_step(input front_t p, input int j, input logic on);
        front_t                  n;
        logic signed [VEC_W-1:0] xs;
        logic signed [VEC_W-1:0] ys;
        logic signed [ANG_W-1:0] at;
        n  = p;
        xs = p.cx >>> j;
        ys = p.cy >>> j;
        at = signed'({1'b0, atan_entry(5'(j))});
        if (on)
        begin
            if (p.cy > 0)
            begin
                n.cx = p.cx + ys;
                n.cy = p.cy - xs;
                n.cz = p.cz + at;
            end
            else
            begin
                n.cx = p.cx - ys;
                n.cy = p.cy + xs;
                n.cz = p.cz - at;
            end
        end
        return n;
    endfunction

    // floor modulo into [-pi, pi)
    function automatic logic signed [VEC_W-1:0] wrap_2pi(input logic signed [VEC_W-1:0] t);
        logic signed [VEC_W-1:0] c;
        logic signed [VEC_W-1:0] res;
        res = t;
        for (int k = 0; k < WRAP_N; k++)
        begin
            c = t + WRAP_OFS[k];
            if (c >= 0 && c < TWO_PI_Q)
            begin
                res = c;
            end
        end
        return res - PI_Q;
    endfunction

    // unwrap toward the reference in two steps, then add the noise mean
    function automatic side_t side_step(input side_t p, input int k,
                                        input logic signed [DATA_W-1:0] noise);
        side_t                   n;
        logic signed [VEC_W-1:0] diff;
        n    = p;
        diff = VEC_W'(p.refa) - p.b;
        if (k == 1)
        begin
            if (diff > PI_Q)
            begin
                n.b = p.b + TWO_PI_Q;
            end
        end
        else if (k == 2)
        begin
            if (diff < -PI_Q)
            begin
                n.b = p.b - TWO_PI_Q;
            end
        end
        else if (k == 3)
        begin
            n.b = VEC_W'(sat32(p.b + VEC_W'(noise)));
        end
        return n;
    endfunction

    function automatic logic [DATA_W-1:0] part_val(input logic [QUO_W-1:0] q,
                                                   input logic sat, input logic neg,
                                                   input logic degen);
        logic [DATA_W-1:0] mag;
        mag = sat ? 32'h7FFF_FFFF : {1'b0, q};
        if (degen)
        begin
            return '0;
        end
        return neg ? -mag : mag;
    endfunction

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    logic signed [DATA_W-1:0] range_noise_reg;
    logic signed [DATA_W-1:0] bearing_noise_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_noise_reg   <= '0;
            bearing_noise_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_RANGE_NOISE:   range_noise_reg   <= cfg_data;
                REG_BEARING_NOISE: bearing_noise_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control: every stage advances together unless a finished
    // result is held by the receiver.
    // ---------------------------------------------------------------
    logic                 adv;
    logic [FRONT_N-1:0]   fv_reg;
    logic                 bv_reg;
    logic [QUO_W-1:0]     sv_reg;
    logic                 result_valid_reg;

    assign adv        = !result_valid_reg || !result_stall;
    assign meas_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg           <= '0;
            bv_reg           <= 1'b0;
            sv_reg           <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            fv_reg           <= {fv_reg[FRONT_N-2:0], meas_valid};
            bv_reg           <= fv_reg[FRONT_N-1];
            sv_reg           <= {sv_reg[QUO_W-2:0], bv_reg};
            result_valid_reg <= sv_reg[QUO_W-1];
        end
    end

    // ---------------------------------------------------------------
    // Front: differences and CORDIC pre-rotation, squares, sum, then
    // the square-root digits with CORDIC steps alongside.
    // ---------------------------------------------------------------
    front_t                fp_reg  [FRONT_N];
    front_t                fp_next [FRONT_N];
    logic [2*DATA_W-1:0]   sx2_reg;
    logic [2*DATA_W-1:0]   sy2_reg;
    logic [2*DATA_W-1:0]   sx2_next;
    logic [2*DATA_W-1:0]   sy2_next;

    always_comb
    begin
        logic signed [DATA_W:0] dx;
        logic signed [DATA_W:0] dy;
        logic [RAD_W-1:0]       sum;
        front_t                 e;

        dx = {beacon_x[DATA_W-1], beacon_x} - {robot_x[DATA_W-1], robot_x};
        dy = {beacon_y[DATA_W-1], beacon_y} - {robot_y[DATA_W-1], robot_y};

        e        = '0;
        e.ax     = dx[DATA_W] ? DATA_W'(-dx) : dx[DATA_W-1:0];
        e.ay     = dy[DATA_W] ? DATA_W'(-dy) : dy[DATA_W-1:0];
        e.dx_pos = !dx[DATA_W] && (dx != '0);
        e.dy_pos = !dy[DATA_W] && (dy != '0);
        e.dy_neg = dy[DATA_W];
        e.hd     = robot_heading;
        e.refa   = reference_angle;
        // rotate by pi into the right half plane
        if (dx[DATA_W])
        begin
            e.cx = -VEC_W'(dx);
            e.cy = -VEC_W'(dy);
            e.cz = dy[DATA_W] ? -PI_ANG : PI_ANG;
        end
        else
        begin
            e.cx = VEC_W'(dx);
            e.cy = VEC_W'(dy);
            e.cz = '0;
        end
        fp_next[0] = e;

        fp_next[1] = fp_reg[0];
        sx2_next   = fp_reg[0].ax * fp_reg[0].ax;
        sy2_next   = fp_reg[0].ay * fp_reg[0].ay;

        sum              = RAD_W'(sx2_reg) + RAD_W'(sy2_reg);
        fp_next[2]       = fp_reg[1];
        fp_next[2].rad   = sum;
        fp_next[2].degen = (sum == '0);

        for (int j = 0; j < ROOT_W; j++)
        begin
            fp_next[3+j] = cordic_step(sqrt_step(fp_reg[2+j], ROOT_W-1-j), j,
                                       (j < CORDIC_STEPS));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fp_reg  <= fp_next;
            sx2_reg <= sx2_next;
            sy2_reg <= sy2_next;
        end
    end

    // ---------------------------------------------------------------
    // r^2 and the angle before wrapping
    // ---------------------------------------------------------------
    back_t bk_reg;
    back_t bk_next;

    always_comb
    begin
        logic signed [ANG_W-1:0] ang;
        front_t                  fl;
        fl             = fp_reg[FRONT_N-1];
        ang            = fl.degen ? '0 : fl.cz;
        bk_next.ax     = fl.ax;
        bk_next.ay     = fl.ay;
        bk_next.r      = fl.root;
        bk_next.r2     = fl.root * fl.root;
        bk_next.t      = VEC_W'(ang) - VEC_W'(fl.hd) + PI_Q;
        bk_next.refa   = fl.refa;
        bk_next.dx_pos = fl.dx_pos;
        bk_next.dy_pos = fl.dy_pos;
        bk_next.dy_neg = fl.dy_neg;
        bk_next.degen  = fl.degen;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bk_reg <= bk_next;
        end
    end

    // ---------------------------------------------------------------
    // Dividers: |d|/r in Q1.30 and |d|/r^2 in Q15.16
    // ---------------------------------------------------------------
    logic [QUO_W-1:0] q_rbx, q_rby, q_bbx, q_bby;
    logic             s_rbx, s_rby, s_bbx, s_bby;

    rbm_divider #(.DW(ROOT_W), .HW(DATA_W), .QW(QUO_W)) u_div_rbx (
        .clk    (clk),
        .en     (adv),
        .num_hi ({1'b0, bk_reg.ax[DATA_W-1:1]}),
        .num_lo ({bk_reg.ax[0], {(QUO_W-1){1'b0}}}),
        .den    (bk_reg.r),
        .quo    (q_rbx),
        .sat    (s_rbx)
    );

    rbm_divider #(.DW(ROOT_W), .HW(DATA_W), .QW(QUO_W)) u_div_rby (
        .clk    (clk),
        .en     (adv),
        .num_hi ({1'b0, bk_reg.ay[DATA_W-1:1]}),
        .num_lo ({bk_reg.ay[0], {(QUO_W-1){1'b0}}}),
        .den    (bk_reg.r),
        .quo    (q_rby),
        .sat    (s_rby)
    );

    rbm_divider #(.DW(R2_W), .HW(DATA_W+1), .QW(QUO_W)) u_div_bbx (
        .clk    (clk),
        .en     (adv),
        .num_hi ({bk_reg.ay, 1'b0}),
        .num_lo ('0),
        .den    (bk_reg.r2),
        .quo    (q_bbx),
        .sat    (s_bbx)
    );

    rbm_divider #(.DW(R2_W), .HW(DATA_W+1), .QW(QUO_W)) u_div_bby (
        .clk    (clk),
        .en     (adv),
        .num_hi ({bk_reg.ax, 1'b0}),
        .num_lo ('0),
        .den    (bk_reg.r2),
        .quo    (q_bby),
        .sat    (s_bby)
    );

    // ---------------------------------------------------------------
    // Side lane: wrap, unwrap, bearing noise, then hold until the
    // quotients arrive.
    // ---------------------------------------------------------------
    side_t sd_reg  [QUO_W];
    side_t sd_next [QUO_W];

    always_comb
    begin
        sd_next[0].b      = wrap_2pi(bk_reg.t);
        sd_next[0].refa   = bk_reg.refa;
        sd_next[0].r      = bk_reg.r;
        sd_next[0].dx_pos = bk_reg.dx_pos;
        sd_next[0].dy_pos = bk_reg.dy_pos;
        sd_next[0].dy_neg = bk_reg.dy_neg;
        sd_next[0].degen  = bk_reg.degen;
        for (int k = 1; k < QUO_W; k++)
        begin
            sd_next[k] = side_step(sd_reg[k-1], k, bearing_noise_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_reg <= sd_next;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic signed [DATA_W-1:0] range_reg, bearing_reg, rbx_reg, rby_reg, bbx_reg, bby_reg;
    logic                     degen_reg;
    side_t                    sl;

    assign sl = sd_reg[QUO_W-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            range_reg   <= sat32(signed'({3'b000, sl.r}) + VEC_W'(range_noise_reg));
            bearing_reg <= sl.b[DATA_W-1:0];
            rbx_reg     <= part_val(q_rbx, s_rbx, sl.dx_pos, sl.degen);
            rby_reg     <= part_val(q_rby, s_rby, sl.dy_pos, sl.degen);
            bbx_reg     <= part_val(q_bbx, s_bbx, sl.dy_neg, sl.degen);
            bby_reg     <= part_val(q_bby, s_bby, sl.dx_pos, sl.degen);
            degen_reg   <= sl.degen;
        end
    end

    assign result_valid      = result_valid_reg;
    assign predicted_range   = range_reg;
    assign predicted_bearing = bearing_reg;
    assign range_by_x        = rbx_reg;
    assign range_by_y        = rby_reg;
    assign bearing_by_x      = bbx_reg;
    assign bearing_by_y      = bby_reg;
    assign degenerate        = degen_reg;

endmodule

/* rtl/rbm_divider.sv */
module rbm_divider #(
    parameter int DW = rbm_pkg::ROOT_W,
    parameter int HW = rbm_pkg::DATA_W,
    parameter int QW = rbm_pkg::QUO_W
) (
    input  logic          clk,
    input  logic          en,
    input  logic [HW-1:0] num_hi,
    input  logic [QW-1:0] num_lo,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo,
    output logic          sat
);
    // Restoring division, one quotient bit per stage. The dividend is
    // num_hi * 2^QW + num_lo; sat flags a quotient of 2^QW or more.

    logic [DW:0]   rem_reg  [QW];
    logic [DW:0]   rem_next [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [DW-1:0] den_prev [QW];
    logic [QW-1:0] lo_reg   [QW];
    logic [QW-1:0] lo_next  [QW];
    logic [QW-1:0] q_reg    [QW];
    logic [QW-1:0] q_next   [QW];
    logic [QW-1:0] sat_reg;
    logic [QW-1:0] sat_prev;

    always_comb
    begin
        logic [DW:0]   p_rem;
        logic [QW-1:0] p_lo;
        logic [QW-1:0] p_q;
        logic [DW:0]   shifted;
        for (int i = 0; i < QW; i++)
        begin
            if (i == 0)
            begin
                p_rem       = (DW+1)'(num_hi);
                p_lo        = num_lo;
                p_q         = '0;
                den_prev[i] = den;
                sat_prev[i] = ((DW+1)'(num_hi) >= {1'b0, den});
            end
            else
            begin
                p_rem       = rem_reg[(i == 0) ? 0 : i-1];
                p_lo        = lo_reg[(i == 0) ? 0 : i-1];
                p_q         = q_reg[(i == 0) ? 0 : i-1];
                den_prev[i] = den_reg[(i == 0) ? 0 : i-1];
                sat_prev[i] = sat_reg[(i == 0) ? 0 : i-1];
            end
            shifted    = {p_rem[DW-1:0], p_lo[QW-1]};
            lo_next[i] = {p_lo[QW-2:0], 1'b0};
            if (shifted >= {1'b0, den_prev[i]})
            begin
                rem_next[i] = shifted - {1'b0, den_prev[i]};
                q_next[i]   = {p_q[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = shifted;
                q_next[i]   = {p_q[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            den_reg <= den_prev;
            lo_reg  <= lo_next;
            q_reg   <= q_next;
            sat_reg <= sat_prev;
        end
    end

    assign quo = q_reg[QW-1];
    assign sat = sat_reg[QW-1];

endmodule

/* tb/range_bearing_measurement_model_core_test.sv */
`timescale 1ns / 1ps

module range_bearing_measurement_model_core_test;

    import rbm_pkg::*;

    // Register index outside the map; the block must drop writes to it.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = REG_BEARING_NOISE + 8'd1;

    localparam int  PIPE_LATENCY = 69;
    localparam int  WATCHDOG_MAX = 4000;
    localparam int  LONG_HOLD    = 300;
    localparam int  RANDOM_ITEMS = 850;
    localparam longint PI_RAD    = 843314856;
    localparam longint TWO_PI    = 1686629713;

    typedef struct {
        logic signed [DATA_W-1:0] rng;
        logic signed [DATA_W-1:0] brg;
        logic signed [DATA_W-1:0] rbx;
        logic signed [DATA_W-1:0] rby;
        logic signed [DATA_W-1:0] bbx;
        logic signed [DATA_W-1:0] bby;
        logic                     degen;
    } observation_t;

    logic                     clk;
    logic                     rst_n;
    logic                     meas_valid;
    logic                     meas_stall;
    logic signed [DATA_W-1:0] robot_x;
    logic signed [DATA_W-1:0] robot_y;
    logic signed [DATA_W-1:0] robot_heading;
    logic signed [DATA_W-1:0] beacon_x;
    logic signed [DATA_W-1:0] beacon_y;
    logic signed [DATA_W-1:0] reference_angle;
    logic                     result_valid;
    logic                     result_stall;
    logic signed [DATA_W-1:0] predicted_range;
    logic signed [DATA_W-1:0] predicted_bearing;
    logic signed [DATA_W-1:0] range_by_x;
    logic signed [DATA_W-1:0] range_by_y;
    logic signed [DATA_W-1:0] bearing_by_x;
    logic signed [DATA_W-1:0] bearing_by_y;
    logic                     degenerate;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DATA_W-1:0]        cfg_data;

    // Predictor copy of the two noise-mean registers.
    longint range_mean;
    longint bearing_mean;

    observation_t pending_obs[$];

    int  n_errors;
    int  n_items;
    int  n_results;
    int  n_cfg_writes;
    int  n_degen_seen;
    int  quiet_cycles;
    bit  no_idle;
    bit  hold_request;

    range_bearing_measurement_model_core i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .meas_valid        (meas_valid),
        .meas_stall        (meas_stall),
        .robot_x           (robot_x),
        .robot_y           (robot_y),
        .robot_heading     (robot_heading),
        .beacon_x          (beacon_x),
        .beacon_y          (beacon_y),
        .reference_angle   (reference_angle),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .predicted_range   (predicted_range),
        .predicted_bearing (predicted_bearing),
        .range_by_x        (range_by_x),
        .range_by_y        (range_by_y),
        .bearing_by_x      (bearing_by_x),
        .bearing_by_y      (bearing_by_y),
        .degenerate        (degenerate),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Jacobian partial: magnitude scaled by 2^sh, divided by r (twice for r^2),
    // truncated and clamped to the positive 32-bit limit, then signed.
    function automatic longint jacobian_term(input longint unsigned mag, input bit neg,
                                             input int sh, input longint unsigned r,
                                             input bit by_r_squared);
        longint unsigned q;
        q = (mag << sh) / r;
        if (by_r_squared)
        begin
            q = q / r;
        end
        if (q > 64'h7FFF_FFFF)
        begin
            q = 64'h7FFF_FFFF;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // Vectoring CORDIC with pi pre-rotation for the left half plane.
    function automatic longint beacon_angle(input longint dy, input longint dx);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint tab;
        x = dx;
        y = dy;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? PI_RAD : -PI_RAD;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS_DEF; i++)
        begin
            xs  = x >>> i;
            ys  = y >>> i;
            tab = longint'(atan_ref(i));
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + tab;
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - tab;
            end
        end
        return z;
    endfunction

    function automatic longint atan_ref(input int i);
        longint tab [32] = '{
            210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
            2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
            4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0
        };
        return tab[i];
    endfunction

    function automatic observation_t predict_observation(
        input logic signed [DATA_W-1:0] rx, input logic signed [DATA_W-1:0] ry,
        input logic signed [DATA_W-1:0] hd, input logic signed [DATA_W-1:0] bx,
        input logic signed [DATA_W-1:0] by, input logic signed [DATA_W-1:0] refa);
        observation_t   o;
        longint         dx;
        longint         dy;
        longint         b;
        longint         ang;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned r;
        logic [65:0]    radicand;
        logic [67:0]    rem;
        logic [67:0]    root;
        logic [67:0]    trial;
        bit             degen;

        dx = longint'(bx) - longint'(rx);
        dy = longint'(by) - longint'(ry);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        radicand = {2'b00, ax} * {2'b00, ax} + {2'b00, ay} * {2'b00, ay};
        degen = (radicand == '0);

        // floor square root, two radicand bits per digit
        rem  = '0;
        root = '0;
        for (int k = 32; k >= 0; k--)
        begin
            rem   = (rem << 2) | radicand[2*k+1 -: 2];
            root  = root << 1;
            trial = (root << 1) | 68'd1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = root | 68'd1;
            end
        end
        r = root[63:0];

        ang = degen ? 0 : beacon_angle(dy, dx);
        b   = ang - longint'(hd);
        b   = (b + PI_RAD) % TWO_PI;
        if (b < 0)
        begin
            b = b + TWO_PI;
        end
        b = b - PI_RAD;
        if (longint'(refa) - b > PI_RAD)
        begin
            b = b + TWO_PI;
        end
        if (longint'(refa) - b < -PI_RAD)
        begin
            b = b - TWO_PI;
        end

        o.rng   = 32'(clamp32(longint'(r) + range_mean));
        o.brg   = 32'(clamp32(b + bearing_mean));
        o.degen = degen;
        if (degen)
        begin
            o.rbx = '0;
            o.rby = '0;
            o.bbx = '0;
            o.bby = '0;
        end
        else
        begin
            o.rbx = 32'(jacobian_term(ax, dx > 0, 30, r, 1'b0));
            o.rby = 32'(jacobian_term(ay, dy > 0, 30, r, 1'b0));
            o.bbx = 32'(jacobian_term(ay, dy < 0, 32, r, 1'b1));
            o.bby = 32'(jacobian_term(ax, dx > 0, 32, r, 1'b1));
        end
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one measurement; return once it has been accepted. Valid stays
    // high after acceptance so back-to-back items carry no bubble.
    task automatic send_measurement(input logic signed [DATA_W-1:0] rx,
                                    input logic signed [DATA_W-1:0] ry,
                                    input logic signed [DATA_W-1:0] hd,
                                    input logic signed [DATA_W-1:0] bx,
                                    input logic signed [DATA_W-1:0] by,
                                    input logic signed [DATA_W-1:0] refa);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            meas_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        meas_valid      = 1'b1;
        robot_x         = rx;
        robot_y         = ry;
        robot_heading   = hd;
        beacon_x        = bx;
        beacon_y        = by;
        reference_angle = refa;
        do
        begin
            @(posedge clk);
        end
        while (meas_stall);
        pending_obs.push_back(predict_observation(rx, ry, hd, bx, by, refa));
        n_items++;
    endtask

    // Drop valid and wait until every expected result has come back,
    // then let the pipe run empty.
    task automatic drain_pipe();
        @(negedge clk);
        meas_valid = 1'b0;
        wait (pending_obs.size() == 0);
        repeat (PIPE_LATENCY + 8) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        if (idx == REG_RANGE_NOISE)
        begin
            range_mean = longint'($signed(value));
        end
        else if (idx == REG_BEARING_NOISE)
        begin
            bearing_mean = longint'($signed(value));
        end
        n_cfg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_noise_means(input logic [DATA_W-1:0] rng_mean,
                                   input logic [DATA_W-1:0] brg_mean);
        drain_pipe();
        write_register(REG_RANGE_NOISE, rng_mean);
        write_register(REG_BEARING_NOISE, brg_mean);
    endtask

    // Random measurement; the mix favors geometry that exercises every
    // quadrant, short ranges and sitting on the beacon.
    task automatic send_random_measurement();
        logic signed [DATA_W-1:0] rx;
        logic signed [DATA_W-1:0] ry;
        logic signed [DATA_W-1:0] bx;
        logic signed [DATA_W-1:0] by;
        logic signed [DATA_W-1:0] hd;
        logic signed [DATA_W-1:0] refa;
        int shape;
        rx    = $urandom;
        ry    = $urandom;
        bx    = $urandom;
        by    = $urandom;
        hd    = $urandom;
        refa  = $urandom;
        shape = $urandom_range(0, 9);
        case (shape)
            0, 1, 2:
            begin
                // keep everything, full 32-bit spread
            end
            3, 4, 5:
            begin
                // beacon a few meters away
                bx = rx + $signed(32'($urandom_range(0, 20 << 16)) - (10 << 16));
                by = ry + $signed(32'($urandom_range(0, 20 << 16)) - (10 << 16));
            end
            6:
            begin
                // a few LSBs apart: saturating bearing partials
                bx = rx + $signed($urandom_range(0, 6)) - 3;
                by = ry + $signed($urandom_range(0, 6)) - 3;
            end
            7:
            begin
                bx = rx;
                by = ry;
            end
            8:
            begin
                // on an axis
                if ($urandom_range(0, 1))
                begin
                    by = ry;
                end
                else
                begin
                    bx = rx;
                end
            end
            default:
            begin
                // angles near the wrap points
                hd   = $signed(32'($urandom_range(0, 2000))) - 1000 + 843314856;
                refa = $urandom_range(0, 1) ? 32'sd843314856 : -32'sd843314856;
            end
        endcase
        if (shape >= 3 && shape <= 5 && $urandom_range(0, 1))
        begin
            // realistic angle ranges about half of the time
            hd   = $signed(32'($urandom_range(0, 1686629712))) - 843314856;
            refa = $signed(32'($urandom_range(0, 1686629712))) - 843314856;
        end
        send_measurement(rx, ry, hd, bx, by, refa);
    endtask

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------

    // Stall at random before each result (never while no_idle is set), or hold
    // off for a long stretch when asked, so the pipe fills and back-pressures the input.
    initial
    begin
        int hold;
        result_stall = 1'b1;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold         = LONG_HOLD;
                hold_request = 1'b0;
            end
            else
            begin
                hold = no_idle ? 0 : $urandom_range(0, 3);
            end
            result_stall = (hold > 0);
            repeat (hold) @(negedge clk);
            result_stall = 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (!result_valid);
        end
    end

    task automatic check_field(input string name, input logic signed [DATA_W-1:0] exp_v,
                               input logic signed [DATA_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            n_errors++;
        end
    endtask

    // Compare every result transaction against the oldest expectation.
    always @(posedge clk)
    begin
        observation_t o;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_obs.size() == 0)
            begin
                $error("result with no measurement outstanding");
                n_errors++;
            end
            else
            begin
                o = pending_obs.pop_front();
                check_field("predicted_range", o.rng, predicted_range);
                check_field("predicted_bearing", o.brg, predicted_bearing);
                check_field("range_by_x", o.rbx, range_by_x);
                check_field("range_by_y", o.rby, range_by_y);
                check_field("bearing_by_x", o.bbx, bearing_by_x);
                check_field("bearing_by_y", o.bby, bearing_by_y);
                check_field("degenerate", 32'(o.degen), 32'(degenerate));
                if (o.degen)
                begin
                    n_degen_seen++;
                end
            end
            n_results++;
        end
    end

    // Watchdog: any accepted transaction on any channel resets the count.
    always @(posedge clk)
    begin
        if ((meas_valid && !meas_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("timeout: %0d measurements still outstanding", pending_obs.size());
            $display("range_bearing_measurement_model_core_test: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_extremes();
        // widest separations, both diagonals and both axes
        send_measurement(32'sh8000_0000, 32'sh8000_0000, 0, 32'sh7FFF_FFFF,
                         32'sh7FFF_FFFF, 0);
        send_measurement(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                         32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_measurement(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                         32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_measurement(32'sh7FFF_FFFF, 0, 0, 32'sh8000_0000, 0, 0);
        send_measurement(0, 32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, 0);
        // one LSB apart: nonzero bearing partials saturate
        send_measurement(0, 0, 0, 1, 0, 0);
        send_measurement(0, 0, 0, 0, -1, 0);
        send_measurement(5, 5, 0, 4, 6, 0);
    endtask

    task automatic test_degenerate();
        send_measurement(0, 0, 0, 0, 0, 0);
        send_measurement(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh1234_5678,
                         32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh0123_4567);
        send_measurement(32'sh0001_0000, -32'sh0002_0000, 32'sh7FFF_FFFF,
                         32'sh0001_0000, -32'sh0002_0000, 32'sh8000_0000);
    endtask

    task automatic test_quadrants();
        // left half plane: pre-rotation by +pi on dy >= 0, -pi below; one right half case
        send_measurement(0, 0, 0, -32'sh0001_0000, 0, 0);
        send_measurement(0, 0, 0, -32'sh0001_0000, 1, 0);
        send_measurement(0, 0, 0, -32'sh0001_0000, -1, 0);
        send_measurement(0, 0, 0, -32'sh0003_0000, -32'sh0004_0000, 32'sd843314856);
        send_measurement(0, 0, 0, 32'sh0003_0000, 32'sh0004_0000, -32'sd843314856);
        // heading wraps and unwrap toward the reference in both directions
        send_measurement(0, 0, -32'sd843314856, 32'sh0001_0000, 0, 32'sh7FFF_FFFF);
        send_measurement(0, 0, 32'sd843314856, 32'sh0001_0000, 0, 32'sh8000_0000);
        send_measurement(0, 0, 32'sd843314856, 32'sh0001_0000, 0, 0);
        send_measurement(0, 0, 32'sd843314857, 32'sh0001_0000, 0, 0);
    endtask

    task automatic test_noise_means();
        // most positive means: range saturates high on a wide separation
        set_noise_means(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_measurement(32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF);
        send_measurement(0, 0, 0, 32'sh0001_0000, 32'sh0001_0000, 0);
        // most negative means: bearing saturates low
        set_noise_means(32'h8000_0000, 32'h8000_0000);
        send_measurement(0, 0, 0, -32'sh0001_0000, -1, 32'sh8000_0000);
        send_measurement(0, 0, 0, 0, 0, 0);
        // an unmapped index leaves both means alone
        drain_pipe();
        write_register(REG_UNMAPPED, 32'h1234_5678);
        send_measurement(0, 0, 0, 32'sh0002_0000, 0, 0);
        set_noise_means(32'h0000_8000, 32'hFF00_0000);
    endtask

    task automatic test_backpressure();
        // hold the receiver off while items keep coming: the pipe must fill
        hold_request = 1'b1;
        no_idle      = 1'b1;
        repeat (120) send_random_measurement();
        no_idle = 1'b0;
        // pause the sender until every result is back
        drain_pipe();
    endtask

    task automatic test_random(input int count);
        repeat (count) send_random_measurement();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n           = 1'b0;
        meas_valid      = 1'b0;
        robot_x         = '0;
        robot_y         = '0;
        robot_heading   = '0;
        beacon_x        = '0;
        beacon_y        = '0;
        reference_angle = '0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        range_mean      = 0;
        bearing_mean    = 0;
        n_errors        = 0;
        n_items         = 0;
        n_results       = 0;
        n_cfg_writes    = 0;
        n_degen_seen    = 0;
        quiet_cycles    = 0;
        no_idle         = 1'b0;
        hold_request    = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_degenerate();
        test_quadrants();
        test_noise_means();
        test_random(RANDOM_ITEMS / 4);
        test_backpressure();
        set_noise_means($urandom, $urandom);
        test_random(RANDOM_ITEMS / 4);
        // a stretch with no idling on either side
        no_idle = 1'b1;
        test_random(100);
        no_idle = 1'b0;
        set_noise_means(32'h0000_0000, 32'h0000_0000);
        test_random(RANDOM_ITEMS / 4);

        drain_pipe();
        if (pending_obs.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_obs.size());
            n_errors++;
        end
        $display("covered %0d measurements, %0d results (%0d on the beacon), %0d register writes",
                 n_items, n_results, n_degen_seen, n_cfg_writes);
        $display("mismatches: %0d", n_errors);
        if (n_errors == 0)
        begin
            $display("range_bearing_measurement_model_core_test: PASS");
        end
        else
        begin
            $display("range_bearing_measurement_model_core_test: FAIL");
        end
        $finish;
    end

endmodule
